[rtl/core/lcgrd_pkg.sv]
package lcgrd_pkg;

	localparam int STATE_BITS  = 48;
	localparam int DRAW_BITS   = 32;
	localparam int U_BITS      = 31;
	localparam int DIGIT_BITS  = 16;
	localparam int NUM_DIGITS  = STATE_BITS / DIGIT_BITS;
	localparam int DIG_W       = 2;
	localparam int DIV_CNT_W   = 5;
	localparam int MAX_TRIES   = 64;
	localparam int TRY_W       = 7;

	localparam logic [STATE_BITS-1:0] MULT_RESET = 48'h0005_DEEC_E66D;
	localparam logic [STATE_BITS-1:0] INCR_RESET = 48'd11;

	// request codes
	localparam logic [2:0] REQ_BITS       = 3'd0;
	localparam logic [2:0] REQ_BOUNDED    = 3'd1;
	localparam logic [2:0] REQ_LONG       = 3'd2;
	localparam logic [2:0] REQ_RESEED_RAW = 3'd3;
	localparam logic [2:0] REQ_RESEED_XOR = 3'd4;

	// register indexes
	localparam logic CFG_MULT = 1'b0;
	localparam logic CFG_INCR = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_MUL,
		ST_MUL_LO,
		ST_BOUND,
		ST_DIV,
		ST_REJ,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		RES_ZERO,
		RES_ERR,
		RES_BITS,
		RES_POW2,
		RES_REM,
		RES_LONG
	} res_sel_t;

	typedef struct packed {
		logic     capture;
		logic     mul_step;
		logic     hi_save;
		logic     div_step;
		logic     try_clr;
		logic     try_inc;
		logic     reseed_raw;
		logic     reseed_xor;
		logic     out_load;
		res_sel_t res_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] req_type;
		logic       bound_bad;
		logic       bound_pow2;
		logic       mul_last;
		logic       div_last;
		logic       accept_ok;
		logic       tries_max;
	} dp_status_t;

endpackage

[rtl/core/lcgrd_ifs.sv]
interface lcgrd_req_if;
	logic               valid;
	logic               ready;
	logic        [2:0]  req_type;
	logic        [5:0]  bit_count;
	logic signed [31:0] upper_bound;
	logic signed [63:0] seed_value;

	modport source(output valid, req_type, bit_count, upper_bound, seed_value, input ready);
	modport sink(input valid, req_type, bit_count, upper_bound, seed_value, output ready);
endinterface

interface lcgrd_res_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] draw_value;
	logic               bound_error;

	modport source(output valid, draw_value, bound_error, input ready);
	modport sink(input valid, draw_value, bound_error, output ready);
endinterface

[rtl/core/lcgrd_ctrl.sv]
module lcgrd_ctrl
	import lcgrd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t st,
	output dp_cmd_t    cmd
);

	state_t   state_q, state_d;
	res_sel_t sel_q, sel_d;
	logic     out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sel_q       <= RES_ZERO;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d     = state_q;
		sel_d       = sel_q;
		cmd         = '0;
		cmd.res_sel = sel_q;
		in_ready    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_DECODE;
				end
			end
			ST_DECODE: begin
				state_d = ST_OUT;
				sel_d   = RES_ZERO;
				case (st.req_type)
					REQ_BITS, REQ_LONG: state_d = ST_MUL;
					REQ_BOUNDED: begin
						if (st.bound_bad) begin
							sel_d = RES_ERR;
						end else begin
							cmd.try_clr = 1'b1;
							state_d     = ST_MUL;
						end
					end
					REQ_RESEED_RAW: cmd.reseed_raw = 1'b1;
					REQ_RESEED_XOR: cmd.reseed_xor = 1'b1;
					default: ;
				endcase
			end
			ST_MUL: begin
				cmd.mul_step = 1'b1;
				if (st.mul_last) begin
					case (st.req_type)
						REQ_BOUNDED: state_d = ST_BOUND;
						REQ_LONG: begin
							cmd.hi_save = 1'b1;
							state_d     = ST_MUL_LO;
						end
						default: begin
							sel_d   = RES_BITS;
							state_d = ST_OUT;
						end
					endcase
				end
			end
			ST_MUL_LO: begin
				cmd.mul_step = 1'b1;
				if (st.mul_last) begin
					sel_d   = RES_LONG;
					state_d = ST_OUT;
				end
			end
			ST_BOUND: begin
				if (st.bound_pow2) begin
					sel_d   = RES_POW2;
					state_d = ST_OUT;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (st.div_last)
					state_d = ST_REJ;
			end
			ST_REJ: begin
				if (st.tries_max || st.accept_ok) begin
					sel_d   = RES_REM;
					state_d = ST_OUT;
				end else begin
					cmd.try_inc = 1'b1;
					state_d     = ST_MUL;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

[rtl/core/lcgrd_dp.sv]
module lcgrd_dp
	import lcgrd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [STATE_BITS-1:0] cfg_data,
	input  logic [2:0]            req_type,
	input  logic [5:0]            bit_count,
	input  logic [31:0]           upper_bound,
	input  logic [63:0]           seed_value,
	input  dp_cmd_t               cmd,
	output dp_status_t            st,
	output logic [63:0]           draw_value,
	output logic                  bound_error
);

	logic [STATE_BITS-1:0] mult_q, incr_q, seed_q, acc_q, sv_q;
	logic [2:0]            type_q;
	logic [5:0]            cnt_q;
	logic [31:0]           bound_q;
	logic [DIG_W-1:0]      dig_q;
	logic [DIV_CNT_W-1:0]  div_cnt_q;
	logic [U_BITS-1:0]     rem_q, dsh_q;
	logic [TRY_W-1:0]      tries_q;
	logic [DRAW_BITS-1:0]  hi_q;
	logic [63:0]           draw_value_q;
	logic                  bound_error_q;

	// congruential step, one 16-bit digit of the seed per cycle
	logic [DIGIT_BITS-1:0] digit;
	logic [63:0]           prod;
	logic [STATE_BITS-1:0] shifted, base, mul_sum;
	logic                  mul_last;

	always_comb begin
		case (dig_q)
			2'd0:    digit = seed_q[15:0];
			2'd1:    digit = seed_q[31:16];
			default: digit = seed_q[47:32];
		endcase
		prod = {48'b0, digit} * {16'b0, mult_q};
		case (dig_q)
			2'd0:    shifted = prod[47:0];
			2'd1:    shifted = {prod[31:0], 16'b0};
			default: shifted = {prod[15:0], 32'b0};
		endcase
		base    = (dig_q == '0) ? incr_q : acc_q;
		mul_sum = base + shifted;
	end

	assign mul_last = (dig_q == DIG_W'(NUM_DIGITS - 1));

	// candidate and remainder
	logic [U_BITS-1:0] u;
	logic [31:0]       m, rej_sum, div_t, div_sub;
	logic [U_BITS-1:0] div_rem_in, div_bits_in;
	logic              div_last;

	assign u        = seed_q[47:17];
	assign m        = bound_q - 32'd1;
	assign rej_sum  = {1'b0, u} - {1'b0, rem_q} + m;
	assign div_last = (div_cnt_q == DIV_CNT_W'(U_BITS - 1));

	always_comb begin
		div_rem_in  = (div_cnt_q == '0) ? '0 : rem_q;
		div_bits_in = (div_cnt_q == '0) ? u : dsh_q;
		div_t       = {div_rem_in, div_bits_in[U_BITS-1]};
		div_sub     = div_t - bound_q;
	end

	// result sources
	logic [5:0]           eff_b;
	logic [DRAW_BITS-1:0] top, bits_val, pow_val;
	logic [61:0]          pow_prod;
	logic [63:0]          long_val;

	always_comb begin
		if (cnt_q > 6'd32)
			eff_b = 6'd32;
		else
			eff_b = cnt_q;
		top      = seed_q[47:16];
		bits_val = top >> (6'd32 - eff_b);
		pow_prod = {31'b0, bound_q[30:0]} * {31'b0, u};
		pow_val  = {1'b0, pow_prod[61:31]};
		long_val = {hi_q, 32'b0} + {{32{top[31]}}, top};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mult_q    <= MULT_RESET;
			incr_q    <= INCR_RESET;
			seed_q    <= '0;
			dig_q     <= '0;
			div_cnt_q <= '0;
			tries_q   <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_MULT)
					mult_q <= cfg_data;
				else
					incr_q <= cfg_data;
			end
			if (cmd.mul_step) begin
				if (mul_last) begin
					seed_q <= mul_sum;
					dig_q  <= '0;
				end else begin
					dig_q <= dig_q + DIG_W'(1);
				end
			end else if (cmd.reseed_raw) begin
				seed_q <= sv_q;
			end else if (cmd.reseed_xor) begin
				seed_q <= sv_q ^ mult_q;
			end
			if (cmd.div_step)
				div_cnt_q <= div_last ? '0 : div_cnt_q + DIV_CNT_W'(1);
			if (cmd.try_clr)
				tries_q <= TRY_W'(1);
			else if (cmd.try_inc)
				tries_q <= tries_q + TRY_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			type_q  <= req_type;
			cnt_q   <= bit_count;
			bound_q <= upper_bound;
			sv_q    <= seed_value[STATE_BITS-1:0];
		end
		if (cmd.mul_step && !mul_last)
			acc_q <= mul_sum;
		if (cmd.hi_save)
			hi_q <= mul_sum[47:16];
		if (cmd.div_step) begin
			rem_q <= div_sub[31] ? div_t[U_BITS-1:0] : div_sub[U_BITS-1:0];
			dsh_q <= div_bits_in << 1;
		end
		if (cmd.out_load) begin
			bound_error_q <= (cmd.res_sel == RES_ERR);
			case (cmd.res_sel)
				RES_BITS: draw_value_q <= {{32{bits_val[31]}}, bits_val};
				RES_POW2: draw_value_q <= {32'b0, pow_val};
				RES_REM:  draw_value_q <= {33'b0, rem_q};
				RES_LONG: draw_value_q <= long_val;
				default:  draw_value_q <= '0;
			endcase
		end
	end

	always_comb begin
		st.req_type   = type_q;
		st.bound_bad  = bound_q[31] || (bound_q == '0);
		st.bound_pow2 = ((bound_q & m) == '0);
		st.mul_last   = mul_last;
		st.div_last   = div_last;
		st.accept_ok  = !rej_sum[31];
		st.tries_max  = (tries_q == TRY_W'(MAX_TRIES));
	end

	assign draw_value  = draw_value_q;
	assign bound_error = bound_error_q;

endmodule

[rtl/core/lcg48_random_draw.sv]
// 48-bit congruential random source: seed = seed * lcg_multiplier + lcg_increment mod 2^48.
// Channels: req (valid/ready) takes one request item: bit draw, bounded int, long, or a
//   raw / scrambled reseed. res (valid/ready) returns exactly one item per request:
//   draw_value (bit draws sign-extended), bound_error for a bounded draw with bound <= 0.
// Config: cfg_we/cfg_index/cfg_data write lcg_multiplier (0) or lcg_increment (1);
//   write only while no request is in flight.
// Work per request (a seed step feeds the 16-bit seed digits to the 16x48 multiplier):
//   reseed, bad bound, unknown code: no step; bit draw: one step; long: two steps;
//   power-of-two bound: one step; other bound: step and bit-serial remainder per draw,
//   up to 64 draws when candidates keep being rejected.
// One request is worked at a time; the next is taken as soon as the result sits in the
//   output register, so a stalled receiver holds back only a second finished result.
// Reset: seed 0, multiplier 0x5DEECE66D, increment 11, no result pending.
module lcg48_random_draw
	import lcgrd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	lcgrd_req_if.sink             req,
	lcgrd_res_if.source           res,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [STATE_BITS-1:0] cfg_data
);

	dp_cmd_t     cmd;
	dp_status_t  st;
	logic [63:0] draw_value;
	logic        bound_error;

	// sequencer: decodes the request and walks the step / remainder / reject loop
	lcgrd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.st        (st),
		.cmd       (cmd)
	);

	// seed, config registers, multiplier, divider and result register
	lcgrd_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.req_type    (req.req_type),
		.bit_count   (req.bit_count),
		.upper_bound (req.upper_bound),
		.seed_value  (req.seed_value),
		.cmd         (cmd),
		.st          (st),
		.draw_value  (draw_value),
		.bound_error (bound_error)
	);

	assign res.draw_value  = $signed(draw_value);
	assign res.bound_error = bound_error;

	// a finished result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!res.valid || res.ready))
		else $error("result register overwritten");

	// one item at a time: no accept in the cycle after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("second item taken while busy");

	// rejection loop stops at the draw limit
	a_try_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.try_inc |-> !st.tries_max)
		else $error("draw limit exceeded");

	// seed step and remainder never run together, nor with result load
	a_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.mul_step, cmd.div_step, cmd.out_load}))
		else $error("datapath commands overlap");

endmodule

[tb/sv/lcg48_random_draw_tb.sv]
`timescale 1ns / 100ps

module lcg48_random_draw_tb
	import lcgrd_pkg::*;
();

	// codes past the last defined request type: block must answer all zero
	localparam logic [2:0] REQ_UNKNOWN_LO = 3'd5;
	localparam logic [2:0] REQ_UNKNOWN_HI = 3'd7;

	// longest quiet spell is a bounded draw that runs out of retries, plus receiver
	// stalls; the limit covers it several times over
	localparam int WATCHDOG_LIMIT = 10000;
	// settle time after the last result, a few times the slowest plain request
	localparam int TAIL_CYCLES    = 64;
	localparam int REPORT_LIMIT   = 10;
	localparam int NUM_PHASES     = 6;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [5:0]  bit_count;
		logic [31:0] upper_bound;
		logic [63:0] seed_value;
	} draw_req_t;

	typedef struct packed {
		logic [63:0] draw_value;
		logic        bound_error;
	} draw_res_t;

	typedef enum logic [1:0] {
		ROW_PREDICT,
		ROW_TYPED,
		ROW_CFG
	} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [STATE_BITS-1:0] cfg_mult;
		logic [STATE_BITS-1:0] cfg_incr;
		draw_req_t             rq;
		draw_res_t             res;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic                  cfg_index;
	logic [STATE_BITS-1:0] cfg_data;

	lcgrd_req_if req_ch ();
	lcgrd_res_if res_ch ();

	lcg48_random_draw u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 8 ns period
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// ------------------------------------------------------------------
	// Predictor: private copy of the seed and the two step registers
	// ------------------------------------------------------------------
	logic [STATE_BITS-1:0] seed_model = '0;
	logic [STATE_BITS-1:0] mult_model = MULT_RESET;
	logic [STATE_BITS-1:0] incr_model = INCR_RESET;

	draw_res_t expected_draws[$];

	int n_bits, n_bounded, n_long, n_reseed, n_unknown;
	int n_bound_err, n_retry_out, n_settings;
	int sent_items, checked_results, failures, idle_cycles;
	bit quiet;

	// one congruential step, then the top nbits of the new seed
	function automatic logic [31:0] step_and_take(int unsigned nbits);
		seed_model = seed_model * mult_model + incr_model;
		return 32'(seed_model >> (STATE_BITS - nbits));
	endfunction

	function automatic logic [31:0] bounded_draw(logic [31:0] bound);
		logic [31:0] mask_m;
		logic [31:0] cand;
		logic [31:0] rem;
		logic [31:0] span;
		logic [63:0] scaled;
		int          tries;
		mask_m = bound - 32'd1;
		cand   = step_and_take(U_BITS);
		if ((bound & mask_m) == 32'd0) begin
			// power of two: multiply-shift, no rejection
			scaled = {32'd0, bound} * {32'd0, cand};
			return scaled[62:31];
		end
		rem = cand % bound;
		for (tries = 1; tries < MAX_TRIES; tries++) begin
			span = cand - rem + mask_m;
			if (!span[31])
				return rem;
			cand = step_and_take(U_BITS);
			rem  = cand % bound;
		end
		// draw limit reached: last remainder stands, no error
		span = cand - rem + mask_m;
		if (span[31])
			n_retry_out++;
		return rem;
	endfunction

	function automatic draw_res_t predict_draw(draw_req_t rq);
		draw_res_t   pr;
		logic [31:0] hi_word;
		logic [31:0] lo_word;
		int unsigned nbits;
		pr = '0;
		case (rq.req_type)
			REQ_BITS: begin
				n_bits++;
				nbits = (rq.bit_count > 6'd32) ? 32 : int'(rq.bit_count);
				if (nbits == 0) begin
					// seed still steps, value stays zero
					void'(step_and_take(DRAW_BITS));
				end else begin
					lo_word       = step_and_take(nbits);
					pr.draw_value = {{32{lo_word[31]}}, lo_word};
				end
			end
			REQ_BOUNDED: begin
				n_bounded++;
				if (rq.upper_bound == 32'd0 || rq.upper_bound[31]) begin
					// bad bound: flag only, seed untouched
					pr.bound_error = 1'b1;
					n_bound_err++;
				end else begin
					pr.draw_value = {32'd0, bounded_draw(rq.upper_bound)};
				end
			end
			REQ_LONG: begin
				n_long++;
				hi_word       = step_and_take(DRAW_BITS);
				lo_word       = step_and_take(DRAW_BITS);
				pr.draw_value = {hi_word, 32'd0} + {{32{lo_word[31]}}, lo_word};
			end
			REQ_RESEED_RAW: begin
				n_reseed++;
				seed_model = rq.seed_value[STATE_BITS-1:0];
			end
			REQ_RESEED_XOR: begin
				n_reseed++;
				seed_model = rq.seed_value[STATE_BITS-1:0] ^ mult_model;
			end
			default: n_unknown++;
		endcase
		return pr;
	endfunction

	// ------------------------------------------------------------------
	// Directed table helpers
	// ------------------------------------------------------------------
	function automatic dir_row_t typed_row(logic [2:0] rt, logic [5:0] cnt, logic [31:0] bound,
			logic [63:0] sv, logic [63:0] val, logic err);
		dir_row_t r;
		r                = '0;
		r.kind           = ROW_TYPED;
		r.rq.req_type    = rt;
		r.rq.bit_count   = cnt;
		r.rq.upper_bound = bound;
		r.rq.seed_value  = sv;
		r.res.draw_value = val;
		r.res.bound_error = err;
		return r;
	endfunction

	function automatic dir_row_t check_row(logic [2:0] rt, logic [5:0] cnt, logic [31:0] bound,
			logic [63:0] sv);
		dir_row_t r;
		r      = typed_row(rt, cnt, bound, sv, 64'd0, 1'b0);
		r.kind = ROW_PREDICT;
		return r;
	endfunction

	function automatic dir_row_t cfg_row(logic [STATE_BITS-1:0] m, logic [STATE_BITS-1:0] i);
		dir_row_t r;
		r          = '0;
		r.kind     = ROW_CFG;
		r.cfg_mult = m;
		r.cfg_incr = i;
		return r;
	endfunction

	// random request: mostly real draws with lively bounds, a little junk
	function automatic draw_req_t rand_request();
		draw_req_t   rq;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 26)      rq.req_type = REQ_BITS;
		else if (pick < 54) rq.req_type = REQ_BOUNDED;
		else if (pick < 72) rq.req_type = REQ_LONG;
		else if (pick < 84) rq.req_type = REQ_RESEED_RAW;
		else if (pick < 96) rq.req_type = REQ_RESEED_XOR;
		else                rq.req_type = 3'($urandom_range(REQ_UNKNOWN_LO, REQ_UNKNOWN_HI));
		// mostly legal counts, sometimes the whole 6-bit field (zero, above 32)
		if ($urandom_range(99) < 85)
			rq.bit_count = 6'($urandom_range(1, 32));
		else
			rq.bit_count = 6'($urandom_range(0, 63));
		pick = $urandom_range(99);
		if (pick < 25)      rq.upper_bound = 32'd1 << $urandom_range(0, 30);
		else if (pick < 45) rq.upper_bound = $urandom_range(1, 100);
		else if (pick < 65) rq.upper_bound = $urandom & 32'h7FFF_FFFF;
		else if (pick < 80) rq.upper_bound = $urandom_range(32'h4000_0001, 32'h7FFF_FFFF);
		else if (pick < 85) rq.upper_bound = 32'd0;
		else if (pick < 90) rq.upper_bound = $urandom | 32'h8000_0000;
		else                rq.upper_bound = $urandom;
		rq.seed_value = {$urandom, $urandom};
		return rq;
	endfunction

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------
	task automatic send_request(draw_req_t rq, bit typed, draw_res_t typed_res);
		draw_res_t pr;
		// random gaps before the item; valid gets one assignment per step
		while (!quiet && $urandom_range(99) < 11) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.req_type    <= rq.req_type;
		req_ch.bit_count   <= rq.bit_count;
		req_ch.upper_bound <= rq.upper_bound;
		req_ch.seed_value  <= rq.seed_value;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		// item taken at this edge: predictor always runs to keep its seed in step
		pr = predict_draw(rq);
		expected_draws.push_back(typed ? typed_res : pr);
		sent_items++;
	endtask

	// hold the sender until every result is back, then load both registers
	task automatic drain_and_configure(logic [STATE_BITS-1:0] m, logic [STATE_BITS-1:0] i);
		req_ch.valid <= 1'b0;
		while (expected_draws.size() != 0)
			@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_MULT;
		cfg_data  <= m;
		@(posedge clk);
		cfg_index <= CFG_INCR;
		cfg_data  <= i;
		@(posedge clk);
		cfg_we     <= 1'b0;
		mult_model  = m;
		incr_model  = i;
		n_settings++;
	endtask

	// ------------------------------------------------------------------
	// Receiver side: ready drops at random, with odds of 11 in 100, outside quiet phases
	// ------------------------------------------------------------------
	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			res_ch.ready <= quiet || ($urandom_range(99) >= 11);
		end
	end

	// compare each result with the oldest pending expectation
	always @(posedge clk) begin
		draw_res_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_draws.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("unexpected result: value %h err %b, nothing pending",
						res_ch.draw_value, res_ch.bound_error);
			end else begin
				want = expected_draws.pop_front();
				checked_results++;
				if (res_ch.draw_value !== want.draw_value ||
						res_ch.bound_error !== want.bound_error) begin
					failures++;
					if (failures <= REPORT_LIMIT)
						$display("result %0d mismatch: expected value %h err %b, got value %h err %b",
							checked_results, want.draw_value, want.bound_error,
							res_ch.draw_value, res_ch.bound_error);
				end
			end
		end
	end

	// watchdog on cycles with no item moving on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: %0d cycles without progress, %0d results pending",
					idle_cycles, expected_draws.size());
				$display("lcg48_random_draw regression: fail");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		dir_row_t              dir_table[$];
		logic [STATE_BITS-1:0] ph_mult[NUM_PHASES];
		logic [STATE_BITS-1:0] ph_incr[NUM_PHASES];
		int                    ph_items[NUM_PHASES];
		bit                    ph_quiet[NUM_PHASES];

		quiet              = 1'b0;
		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_index          <= CFG_MULT;
		cfg_data           <= '0;
		req_ch.valid       <= 1'b0;
		req_ch.req_type    <= REQ_BITS;
		req_ch.bit_count   <= '0;
		req_ch.upper_bound <= '0;
		req_ch.seed_value  <= '0;

		// after reset the seed is 0, so the first step lands on 11: top bits all zero
		dir_table.push_back(typed_row(REQ_BITS, 6'd32, 32'd0, 64'd0, 64'd0, 1'b0));
		dir_table.push_back(check_row(REQ_BITS, 6'd1, 32'd0, 64'd0));
		// zero bit count still steps the seed
		dir_table.push_back(typed_row(REQ_BITS, 6'd0, 32'd0, 64'd0, 64'd0, 1'b0));
		// counts above 32 behave as 32
		dir_table.push_back(check_row(REQ_BITS, 6'd63, 32'd0, 64'd0));
		dir_table.push_back(check_row(REQ_BITS, 6'd33, 32'd0, 64'd0));
		// non-positive bounds: flag, zero value, no step
		dir_table.push_back(typed_row(REQ_BOUNDED, 6'd0, 32'd0, 64'd0, 64'd0, 1'b1));
		dir_table.push_back(typed_row(REQ_BOUNDED, 6'd0, 32'hFFFF_FFFF, 64'd0, 64'd0, 1'b1));
		dir_table.push_back(typed_row(REQ_BOUNDED, 6'd0, 32'h8000_0000, 64'd0, 64'd0, 1'b1));
		// bound of one can only give zero
		dir_table.push_back(typed_row(REQ_BOUNDED, 6'd0, 32'd1, 64'd0, 64'd0, 1'b0));
		dir_table.push_back(check_row(REQ_BOUNDED, 6'd0, 32'h4000_0000, 64'd0));
		dir_table.push_back(check_row(REQ_BOUNDED, 6'd0, 32'h7FFF_FFFF, 64'd0));
		dir_table.push_back(check_row(REQ_BOUNDED, 6'd0, 32'd7, 64'd0));
		dir_table.push_back(check_row(REQ_LONG, 6'd0, 32'd0, 64'd0));
		// all-ones seed: next 32-bit draw comes out negative
		dir_table.push_back(typed_row(REQ_RESEED_RAW, 6'd0, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF,
			64'd0, 1'b0));
		dir_table.push_back(check_row(REQ_BITS, 6'd32, 32'd0, 64'd0));
		dir_table.push_back(check_row(REQ_LONG, 6'd0, 32'd0, 64'd0));
		// scrambled reseed with the multiplier itself clears the seed; top bits dropped
		dir_table.push_back(typed_row(REQ_RESEED_XOR, 6'd0, 32'd0, {16'hFFFF, MULT_RESET},
			64'd0, 1'b0));
		dir_table.push_back(typed_row(REQ_BITS, 6'd32, 32'd0, 64'd0, 64'd0, 1'b0));
		dir_table.push_back(typed_row(REQ_UNKNOWN_LO, 6'd32, 32'd5, 64'd5, 64'd0, 1'b0));
		dir_table.push_back(typed_row(REQ_UNKNOWN_HI, 6'd63, 32'hFFFF_FFFF,
			64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 1'b0));
		// frozen generator: every candidate for 2^30+1 is rejected, retries run out
		dir_table.push_back(cfg_row(48'd1, 48'd0));
		dir_table.push_back(typed_row(REQ_RESEED_RAW, 6'd0, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF,
			64'd0, 1'b0));
		dir_table.push_back(check_row(REQ_BOUNDED, 6'd0, 32'h4000_0001, 64'd0));
		dir_table.push_back(check_row(REQ_BOUNDED, 6'd0, 32'd8, 64'd0));
		dir_table.push_back(check_row(REQ_LONG, 6'd0, 32'd0, 64'd0));
		dir_table.push_back(cfg_row(MULT_RESET, INCR_RESET));

		// random phases: defaults, both extremes of each register, random settings
		ph_mult[0] = MULT_RESET;            ph_incr[0] = INCR_RESET;
		ph_mult[1] = '1;                    ph_incr[1] = '0;
		ph_mult[2] = '0;                    ph_incr[2] = '1;
		ph_mult[3] = 48'({$urandom, $urandom}); ph_incr[3] = 48'({$urandom, $urandom});
		ph_mult[4] = 48'({$urandom, $urandom}); ph_incr[4] = '1;
		ph_mult[5] = MULT_RESET;            ph_incr[5] = 48'({$urandom, $urandom});
		ph_items   = '{300, 150, 100, 200, 200, 150};
		// phase 1 runs with neither side idling
		ph_quiet   = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_table[k]) begin
			if (dir_table[k].kind == ROW_CFG)
				drain_and_configure(dir_table[k].cfg_mult, dir_table[k].cfg_incr);
			else
				send_request(dir_table[k].rq, dir_table[k].kind == ROW_TYPED,
					dir_table[k].res);
		end

		// each phase change also makes the sender wait for every pending result
		for (int p = 0; p < NUM_PHASES; p++) begin
			quiet = 1'b0;
			drain_and_configure(ph_mult[p], ph_incr[p]);
			quiet = ph_quiet[p];
			repeat (ph_items[p])
				send_request(rand_request(), 1'b0, '0);
		end
		quiet = 1'b0;

		req_ch.valid <= 1'b0;
		while (expected_draws.size() != 0)
			@(posedge clk);
		// catch any stray result after the last one
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("sent %0d requests: %0d bit, %0d bounded, %0d long, %0d reseed, %0d unknown",
			sent_items, n_bits, n_bounded, n_long, n_reseed, n_unknown);
		$display("%0d register settings, %0d bad bounds, %0d retry run-outs, %0d results, %0d bad",
			n_settings, n_bound_err, n_retry_out, checked_results, failures);
		if (failures == 0 && expected_draws.size() == 0)
			$display("lcg48_random_draw regression: pass");
		else
			$display("lcg48_random_draw regression: fail");
		$finish;
	end

endmodule
